/* hdl/ledss_pkg.sv */
// Shared types, codes and constants of the LED serial frame sender.
package ledss_pkg;

  localparam int DISPLAY_BYTES_DEF = 14;
  localparam int CNT_W             = 4;
  localparam int BRIGHT_W          = 3;

  localparam logic [7:0]          MODE_BYTE   = 8'h03;
  localparam logic [7:0]          DCMD_BYTE   = 8'h40;
  localparam logic [7:0]          ADDR_BYTE   = 8'hC0;
  localparam logic [7:0]          CTRL_BYTE   = 8'h88;
  localparam logic [BRIGHT_W-1:0] BRIGHT_RST  = 3'd7;

  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_START = 2'd2
  } kind_t;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_PRE_MODE = 4'd1,
    PH_MODE     = 4'd2,
    PH_HI_A     = 4'd3,
    PH_LO_A     = 4'd4,
    PH_DCMD     = 4'd5,
    PH_HI_B     = 4'd6,
    PH_LO_B     = 4'd7,
    PH_ADDR     = 4'd8,
    PH_DATA     = 4'd9,
    PH_HI_C     = 4'd10,
    PH_LO_C     = 4'd11,
    PH_PRE_CTRL = 4'd12,
    PH_CTRL     = 4'd13,
    PH_HI_END   = 4'd14
  } phase_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] digit_index;
    logic [7:0] byte_value;
  } item_t;

  typedef struct packed {
    logic strobe_pin;
    logic clock_pin;
    logic data_pin;
    logic busy_res;
    logic rejected;
  } res_t;

endpackage

/* hdl/ledss_in_stage.sv */
// Input register of the frame sender: holds one accepted transaction.
module ledss_in_stage import ledss_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  item_t      in_item,
  input  logic       advance,
  output logic       item_valid,
  output item_t      item
);

  logic  valid_r;
  item_t item_r;
  logic  accept;

  assign in_stall   = valid_r && !advance;
  assign accept     = in_valid && !in_stall;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (accept) begin
      valid_r <= 1'b1;
    end else if (advance) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_item;
    end
  end

endmodule

/* hdl/ledss_core.sv */
// Frame sequencer, display store and brightness register.
module ledss_core import ledss_pkg::*; #(
  parameter int DISPLAY_BYTES = DISPLAY_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [BRIGHT_W-1:0] cfg_wr_data,
  input  logic                proc,
  input  item_t               item,
  output res_t                res
);

  localparam int IDX_W = (DISPLAY_BYTES > 1) ? $clog2(DISPLAY_BYTES) : 1;
  localparam logic [CNT_W:0] NBYTES = (CNT_W+1)'(DISPLAY_BYTES);

  logic [7:0]          store_r [DISPLAY_BYTES];
  logic [BRIGHT_W-1:0] bright_r;
  phase_t              phase_r, phase_nxt;
  logic [CNT_W-1:0]    byte_r, byte_nxt;
  logic [2:0]          bit_r, bit_nxt;
  logic                half_r, half_nxt;
  logic                stb_r, stb_nxt;
  logic                clk_r, clk_nxt;
  logic                dat_r, dat_nxt;
  logic                rej;
  logic                store_we;
  logic                busy;
  logic [7:0]          cur_byte;
  kind_t               kind;

  assign kind = kind_t'(item.kind);
  assign busy = (phase_r != PH_IDLE);

  always_comb begin
    case (phase_r)
      PH_MODE: cur_byte = MODE_BYTE;
      PH_DCMD: cur_byte = DCMD_BYTE;
      PH_ADDR: cur_byte = ADDR_BYTE;
      PH_DATA: cur_byte = store_r[byte_r[IDX_W-1:0]];
      PH_CTRL: cur_byte = CTRL_BYTE | {5'd0, bright_r};
      default: cur_byte = 8'h00;
    endcase
  end

  // Next state of the sequencer and pins for the transaction in the input register.
  always_comb begin
    phase_nxt = phase_r;
    byte_nxt  = byte_r;
    bit_nxt   = bit_r;
    half_nxt  = half_r;
    stb_nxt   = stb_r;
    clk_nxt   = clk_r;
    dat_nxt   = dat_r;
    store_we  = 1'b0;
    case (kind)
      KIND_TICK: begin
        if (busy) begin
          case (phase_r)
            PH_PRE_MODE: phase_nxt = PH_MODE;
            PH_HI_A: begin
              stb_nxt = 1'b1; phase_nxt = PH_LO_A;
            end
            PH_LO_A: begin
              stb_nxt = 1'b0; phase_nxt = PH_DCMD;
            end
            PH_HI_B: begin
              stb_nxt = 1'b1; phase_nxt = PH_LO_B;
            end
            PH_LO_B: begin
              stb_nxt = 1'b0; phase_nxt = PH_ADDR;
            end
            PH_HI_C: begin
              stb_nxt = 1'b1; phase_nxt = PH_LO_C;
            end
            PH_LO_C: begin
              stb_nxt = 1'b0; phase_nxt = PH_PRE_CTRL;
            end
            PH_PRE_CTRL: phase_nxt = PH_CTRL;
            PH_HI_END: begin
              stb_nxt = 1'b1; phase_nxt = PH_IDLE;
            end
            PH_MODE, PH_DCMD, PH_ADDR, PH_DATA, PH_CTRL: begin
              if (!half_r) begin
                // first half of a bit: clock low, data set
                clk_nxt  = 1'b0;
                dat_nxt  = cur_byte[bit_r];
                half_nxt = 1'b1;
              end else begin
                clk_nxt  = 1'b1;
                half_nxt = 1'b0;
                if (bit_r == 3'd7) begin
                  bit_nxt = 3'd0;
                  case (phase_r)
                    PH_MODE: phase_nxt = PH_HI_A;
                    PH_DCMD: phase_nxt = PH_HI_B;
                    PH_ADDR: begin
                      phase_nxt = PH_DATA; byte_nxt = '0;
                    end
                    PH_DATA: begin
                      if (({1'b0, byte_r} + 1'b1) < NBYTES) begin
                        byte_nxt = byte_r + 1'b1;
                      end else begin
                        phase_nxt = PH_HI_C;
                      end
                    end
                    default: phase_nxt = PH_HI_END;
                  endcase
                end else begin
                  bit_nxt = bit_r + 3'd1;
                end
              end
            end
            default: phase_nxt = PH_IDLE;
          endcase
        end
      end
      KIND_WRITE: begin
        if (!busy && ({1'b0, item.digit_index} < NBYTES)) begin
          store_we = 1'b1;
        end
      end
      KIND_START: begin
        if (!busy) begin
          stb_nxt   = 1'b0;
          phase_nxt = PH_PRE_MODE;
          byte_nxt  = '0;
          bit_nxt   = 3'd0;
          half_nxt  = 1'b0;
        end
      end
      default: ;
    endcase
  end

  // Result fields.
  always_comb begin
    rej = busy && ((kind == KIND_WRITE) || (kind == KIND_START));
    res.strobe_pin = stb_nxt;
    res.clock_pin  = clk_nxt;
    res.data_pin   = dat_nxt;
    res.busy_res   = (phase_nxt != PH_IDLE);
    res.rejected   = rej;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      byte_r  <= '0;
      bit_r   <= 3'd0;
      half_r  <= 1'b0;
      stb_r   <= 1'b1;
      clk_r   <= 1'b1;
      dat_r   <= 1'b0;
    end else if (proc) begin
      phase_r <= phase_nxt;
      byte_r  <= byte_nxt;
      bit_r   <= bit_nxt;
      half_r  <= half_nxt;
      stb_r   <= stb_nxt;
      clk_r   <= clk_nxt;
      dat_r   <= dat_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bright_r <= BRIGHT_RST;
    end else if (cfg_wr_en) begin
      bright_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DISPLAY_BYTES; i++) begin
        store_r[i] <= 8'h00;
      end
    end else if (proc && store_we) begin
      store_r[item.digit_index[IDX_W-1:0]] <= item.byte_value;
    end
  end

endmodule

/* hdl/ledss_out_stage.sv */
// Result register of the frame sender.
module ledss_out_stage import ledss_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic item_valid,
  input  res_t res,
  output logic advance,
  output logic out_valid,
  input  logic out_stall,
  output res_t out_res
);

  logic valid_r;
  res_t res_r;

  // take a new result when the register is empty or being drained
  assign advance   = item_valid && (!valid_r || !out_stall);
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res;
    end
  end

endmodule

/* hdl/led_driver_serial_frame_sender_unit.sv */
// Top level of the LED serial frame sender.
//
// Drives the strobe, clock and data lines of an LED controller. Each input
// transaction is a tick (one delay period), a display byte write, a frame
// start or an unused kind that changes nothing; each one yields exactly one
// result transaction with the line levels, a busy flag and a rejected flag
// (write or start refused during a frame). Both channels use valid/stall; a
// transaction moves when valid is high and stall is low.
// An accepted input waits in the input register, its result in the result
// register. Throughput: one transaction per cycle while out_stall is low;
// the input register feeds the sequencer and the result register directly.
// When the receiver stalls, the result register holds; the input register
// still takes one more transaction, then in_stall rises until the result
// register drains.
// Reset (rst_n low, synchronous) empties both registers, clears the display
// store, sets brightness to 7 and returns the lines to strobe high, clock
// high, data low. Brightness is written through cfg_wr_en / cfg_wr_data.
module led_driver_serial_frame_sender_unit import ledss_pkg::*; #(
  parameter int DISPLAY_BYTES = DISPLAY_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [BRIGHT_W-1:0] cfg_wr_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          in_kind,
  input  logic [3:0]          in_digit_index,
  input  logic [7:0]          in_byte_value,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_strobe_pin,
  output logic                out_clock_pin,
  output logic                out_data_pin,
  output logic                out_busy_res,
  output logic                out_rejected
);

  item_t in_item, item;
  logic  item_valid;
  logic  advance;
  res_t  res, out_res;

  assign in_item.kind        = in_kind;
  assign in_item.digit_index = in_digit_index;
  assign in_item.byte_value  = in_byte_value;

  ledss_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  ledss_core #(
    .DISPLAY_BYTES (DISPLAY_BYTES)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .proc        (advance),
    .item        (item),
    .res         (res)
  );

  ledss_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .res        (res),
    .advance    (advance),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_res    (out_res)
  );

  assign out_strobe_pin = out_res.strobe_pin;
  assign out_clock_pin  = out_res.clock_pin;
  assign out_data_pin   = out_res.data_pin;
  assign out_busy_res   = out_res.busy_res;
  assign out_rejected   = out_res.rejected;

endmodule

/* hdl/ledss_checker.sv */
// Port-level checker for the frame sender, bound to the top level.
module ledss_checker (
  input logic clk,
  input logic rst_n,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic out_strobe_pin,
  input logic out_clock_pin,
  input logic out_data_pin,
  input logic out_busy_res,
  input logic out_rejected
);

  // input side never stalls unless the result side does
  assert property (@(posedge clk) disable iff (!rst_n)
    !out_stall |-> !in_stall)
    else $error("in_stall high while out_stall low");

  // a stalled result holds
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_strobe_pin)
      && $stable(out_clock_pin) && $stable(out_data_pin)
      && $stable(out_busy_res) && $stable(out_rejected)))
    else $error("stalled result changed");

  // rejection only happens during a frame, which it does not end
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_rejected) |-> out_busy_res)
    else $error("rejected while idle");

  // idle lines rest with strobe and clock high
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_busy_res) |-> (out_strobe_pin && out_clock_pin))
    else $error("idle with strobe or clock low");

endmodule

bind led_driver_serial_frame_sender_unit ledss_checker u_ledss_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_strobe_pin (out_strobe_pin),
  .out_clock_pin  (out_clock_pin),
  .out_data_pin   (out_data_pin),
  .out_busy_res   (out_busy_res),
  .out_rejected   (out_rejected)
);

/* tb/led_driver_serial_frame_sender_unit_test.sv */
// Self-checking testbench for the LED serial frame sender: directed steps, then random frames.
`timescale 1ns / 100ps

module led_driver_serial_frame_sender_unit_test;
  import ledss_pkg::*;

  localparam int NUM_BYTES = DISPLAY_BYTES_DEF;
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int HOLD_CYCLES = 40;

  // Line levels packed as strobe, clock, data, busy, rejected.
  localparam res_t IDLE_LINES    = 5'b11000;
  localparam res_t FRAME_OPEN    = 5'b01010;
  localparam res_t FRAME_REFUSED = 5'b01011;

  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] idx;
    logic [7:0] val;
    logic       typed;
    res_t       want;
  } step_row_t;

  localparam int NUM_ROWS = 24;
  localparam step_row_t SCRIPT [NUM_ROWS] = '{
    '{KIND_TICK,   4'd0,  8'h00, 1'b1, IDLE_LINES},
    '{KIND_UNUSED, 4'd15, 8'hFF, 1'b1, IDLE_LINES},
    '{KIND_WRITE,  4'd0,  8'hFF, 1'b1, IDLE_LINES},
    '{KIND_WRITE,  4'd13, 8'h80, 1'b1, IDLE_LINES},
    '{KIND_WRITE,  4'd14, 8'h55, 1'b1, IDLE_LINES},
    '{KIND_WRITE,  4'd15, 8'hAA, 1'b1, IDLE_LINES},
    '{KIND_WRITE,  4'd1,  8'h01, 1'b1, IDLE_LINES},
    '{KIND_WRITE,  4'd12, 8'h7E, 1'b1, IDLE_LINES},
    '{KIND_START,  4'd0,  8'h00, 1'b1, FRAME_OPEN},
    '{KIND_WRITE,  4'd3,  8'h33, 1'b1, FRAME_REFUSED},
    '{KIND_START,  4'd0,  8'h00, 1'b1, FRAME_REFUSED},
    '{KIND_UNUSED, 4'd0,  8'h00, 1'b1, FRAME_OPEN},
    '{KIND_TICK,   4'd0,  8'h00, 1'b0, '0},
    '{KIND_TICK,   4'd0,  8'h00, 1'b0, '0},
    '{KIND_TICK,   4'd0,  8'h00, 1'b0, '0},
    '{KIND_TICK,   4'd0,  8'h00, 1'b0, '0},
    '{KIND_TICK,   4'd0,  8'h00, 1'b0, '0},
    '{KIND_TICK,   4'd0,  8'h00, 1'b0, '0},
    '{KIND_TICK,   4'd0,  8'h00, 1'b0, '0},
    '{KIND_TICK,   4'd0,  8'h00, 1'b0, '0},
    '{KIND_WRITE,  4'd15, 8'hFF, 1'b0, '0},
    '{KIND_TICK,   4'd0,  8'h00, 1'b0, '0},
    '{KIND_TICK,   4'd0,  8'h00, 1'b0, '0},
    '{KIND_START,  4'd7,  8'h00, 1'b0, '0}
  };

  logic                clk = 1'b0;
  logic                rst_n;
  logic                cfg_wr_en;
  logic [BRIGHT_W-1:0] cfg_wr_data;
  logic                in_valid;
  logic                in_stall;
  logic [1:0]          in_kind;
  logic [3:0]          in_digit_index;
  logic [7:0]          in_byte_value;
  logic                out_valid;
  logic                out_stall;
  logic                out_strobe_pin;
  logic                out_clock_pin;
  logic                out_data_pin;
  logic                out_busy_res;
  logic                out_rejected;

  led_driver_serial_frame_sender_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_kind        (in_kind),
    .in_digit_index (in_digit_index),
    .in_byte_value  (in_byte_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_strobe_pin (out_strobe_pin),
    .out_clock_pin  (out_clock_pin),
    .out_data_pin   (out_data_pin),
    .out_busy_res   (out_busy_res),
    .out_rejected   (out_rejected)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state: display store, sequencer position, line levels, brightness.
  logic [7:0]          m_store [NUM_BYTES];
  phase_t              m_phase;
  logic [3:0]          m_byte;
  logic [2:0]          m_bit;
  logic                m_half;
  logic                m_stb, m_clk, m_dat;
  logic [BRIGHT_W-1:0] m_bright;

  res_t pending_levels [$];
  int   mismatches = 0;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  int   hold_requests = 0;

  function automatic res_t next_line_levels(input logic [1:0] kind, input logic [3:0] idx,
                                            input logic [7:0] val);
    logic       busy;
    logic       rej;
    logic [7:0] cur;
    busy = (m_phase != PH_IDLE);
    rej  = 1'b0;
    if (kind == KIND_TICK) begin
      if (busy) begin
        case (m_phase)
          PH_PRE_MODE: m_phase = PH_MODE;
          PH_HI_A: begin m_stb = 1'b1; m_phase = PH_LO_A; end
          PH_LO_A: begin m_stb = 1'b0; m_phase = PH_DCMD; end
          PH_HI_B: begin m_stb = 1'b1; m_phase = PH_LO_B; end
          PH_LO_B: begin m_stb = 1'b0; m_phase = PH_ADDR; end
          PH_HI_C: begin m_stb = 1'b1; m_phase = PH_LO_C; end
          PH_LO_C: begin m_stb = 1'b0; m_phase = PH_PRE_CTRL; end
          PH_PRE_CTRL: m_phase = PH_CTRL;
          PH_HI_END: begin m_stb = 1'b1; m_phase = PH_IDLE; end
          PH_MODE, PH_DCMD, PH_ADDR, PH_DATA, PH_CTRL: begin
            case (m_phase)
              PH_MODE: cur = MODE_BYTE;
              PH_DCMD: cur = DCMD_BYTE;
              PH_ADDR: cur = ADDR_BYTE;
              PH_DATA: cur = m_store[m_byte];
              default: cur = CTRL_BYTE | {5'd0, m_bright};
            endcase
            // First half drops the clock and puts the bit out, second half raises it.
            if (!m_half) begin
              m_clk  = 1'b0;
              m_dat  = cur[m_bit];
              m_half = 1'b1;
            end else begin
              m_clk  = 1'b1;
              m_half = 1'b0;
              if (m_bit == 3'd7) begin
                m_bit = 3'd0;
                case (m_phase)
                  PH_MODE: m_phase = PH_HI_A;
                  PH_DCMD: m_phase = PH_HI_B;
                  PH_ADDR: begin m_phase = PH_DATA; m_byte = 4'd0; end
                  PH_DATA: begin
                    if (int'(m_byte) + 1 < NUM_BYTES) m_byte = m_byte + 4'd1;
                    else m_phase = PH_HI_C;
                  end
                  default: m_phase = PH_HI_END;
                endcase
              end else begin
                m_bit = m_bit + 3'd1;
              end
            end
          end
          default: m_phase = PH_IDLE;
        endcase
      end
    end else if (kind == KIND_WRITE || kind == KIND_START) begin
      if (busy) begin
        rej = 1'b1;
      end else if (kind == KIND_WRITE) begin
        if (int'(idx) < NUM_BYTES) m_store[idx] = val;
      end else begin
        m_stb   = 1'b0;
        m_phase = PH_PRE_MODE;
        m_byte  = 4'd0;
        m_bit   = 3'd0;
        m_half  = 1'b0;
      end
    end
    return res_t'({m_stb, m_clk, m_dat, m_phase != PH_IDLE, rej});
  endfunction

  // Call at a falling edge; returns at the falling edge after the transaction.
  task automatic send_item(input logic [1:0] kind, input logic [3:0] idx, input logic [7:0] val,
                           input logic typed, input res_t want);
    res_t guess;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_kind        <= kind;
    in_digit_index <= idx;
    in_byte_value  <= val;
    do @(posedge clk); while (in_stall);
    guess = next_line_levels(kind, idx, val);
    pending_levels.push_back(typed ? want : guess);
    @(negedge clk);
  endtask

  task automatic set_brightness(input logic [BRIGHT_W-1:0] level);
    in_valid <= 1'b0;
    while (pending_levels.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= level;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    m_bright = level;
  endtask

  task automatic run_random(input int count, input bit with_hold);
    logic [1:0] kind;
    logic [3:0] idx;
    logic [7:0] val;
    int         sel;
    for (int n = 0; n < count; n++) begin
      if (with_hold && n == count / 2) hold_requests++;
      sel = $urandom_range(99);
      val = 8'($urandom);
      idx = 4'($urandom_range(NUM_BYTES - 1));
      if (m_phase != PH_IDLE) begin
        // Keep the frame moving; sprinkle refused writes and starts.
        if (sel < 94) begin
          kind = KIND_TICK;
        end else if (sel < 96) begin
          kind = KIND_WRITE;
          idx  = 4'($urandom);
        end else if (sel < 98) begin
          kind = KIND_START;
        end else begin
          kind = KIND_UNUSED;
        end
      end else begin
        if (sel < 55) begin
          kind = KIND_WRITE;
        end else if (sel < 65) begin
          kind = KIND_WRITE;
          idx  = 4'($urandom_range(15, NUM_BYTES));
        end else if (sel < 72) begin
          kind = KIND_UNUSED;
        end else if (sel < 82) begin
          kind = KIND_TICK;
        end else begin
          kind = KIND_START;
        end
      end
      send_item(kind, idx, val, 1'b0, '0);
    end
  endtask

  function automatic void check_pin(input string name, input logic want, input logic got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0b, got %0b", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : result_monitor
    res_t got;
    res_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_strobe_pin, out_clock_pin, out_data_pin, out_busy_res, out_rejected};
      if (pending_levels.size() == 0) begin
        $display("%0t: unexpected result transaction, expected none, got %b", $time, got);
        mismatches++;
      end else begin
        want = pending_levels.pop_front();
        check_pin("strobe_pin", want.strobe_pin, got.strobe_pin);
        check_pin("clock_pin", want.clock_pin, got.clock_pin);
        check_pin("data_pin", want.data_pin, got.data_pin);
        check_pin("busy_res", want.busy_res, got.busy_res);
        check_pin("rejected", want.rejected, got.rejected);
      end
    end
  end

  // Receiver: random stall, with a long hold-off whenever one is requested.
  initial begin : result_sink
    int hold_left;
    int holds_done;
    hold_left  = 0;
    holds_done = 0;
    out_stall  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (holds_done != hold_requests) begin
        holds_done++;
        hold_left = HOLD_CYCLES - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  initial begin : stimulus
    rst_n          = 1'b0;
    cfg_wr_en      = 1'b0;
    cfg_wr_data    = '0;
    in_valid       = 1'b0;
    in_kind        = KIND_TICK;
    in_digit_index = '0;
    in_byte_value  = '0;
    foreach (m_store[i]) m_store[i] = 8'h00;
    m_phase  = PH_IDLE;
    m_byte   = 4'd0;
    m_bit    = 3'd0;
    m_half   = 1'b0;
    m_stb    = 1'b1;
    m_clk    = 1'b1;
    m_dat    = 1'b0;
    m_bright = BRIGHT_RST;
    send_idle_pct = 34;
    recv_idle_pct = 71;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < NUM_ROWS; r++) begin
      send_item(SCRIPT[r].kind, SCRIPT[r].idx, SCRIPT[r].val, SCRIPT[r].typed, SCRIPT[r].want);
    end

    set_brightness(3'd0);
    run_random(175, 1'b1);

    send_idle_pct = 71;
    recv_idle_pct = 34;
    set_brightness(3'd7);
    run_random(175, 1'b0);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_brightness(3'($urandom_range(6, 1)));
    run_random(175, 1'b0);

    in_valid <= 1'b0;
    while (pending_levels.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mismatches == 0 && pending_levels.size() == 0) begin
      $display("led_driver_serial_frame_sender_unit_test: done, clean");
    end else begin
      $display("led_driver_serial_frame_sender_unit_test: done, errors");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("led_driver_serial_frame_sender_unit_test: done, errors");
    $finish;
  end

endmodule
